/* rtl/bbp_pkg.sv */
// ============================================================================
// bbp_pkg: shared types and constants for the bicubic Bezier patch evaluator
// Holds the beat layouts, the micro-op encoding of the shared multiply-
// accumulate unit and the fixed schedule of the basis weight computation.
// ============================================================================
package bbp_pkg;

    // Field widths and fixed-point formats.
    localparam int COORD_W     = 32;
    localparam int PARAM_W     = 17;
    localparam int PARAM_FRAC  = 16;
    localparam int THREE_W     = PARAM_W + 2;
    localparam int SQ_W        = 2 * PARAM_W - 1;
    localparam int WEIGHT_BITS = 62 - COORD_W;
    localparam int WEIGHT_DROP = 3 * PARAM_FRAC - WEIGHT_BITS;
    localparam int WT_W        = WEIGHT_BITS + 1;
    localparam int OP_W        = COORD_W + 2;
    localparam int ACC_W       = 2 * OP_W;

    // Control point store.
    localparam int NUM_POINTS = 16;
    localparam int POINT_AW   = $clog2(NUM_POINTS);
    localparam int POINT_W    = 3 * COORD_W;

    localparam logic [PARAM_W-1:0] PARAM_ONE = PARAM_W'(1) << PARAM_FRAC;

    // Rounding offsets preloaded into the accumulator on the first product.
    localparam logic signed [ACC_W-1:0] HALF_WEIGHT = ACC_W'(1) << (WEIGHT_DROP - 1);
    localparam logic signed [ACC_W-1:0] HALF_ROUND  = ACC_W'(1) << (WEIGHT_BITS - 1);

    // Saturation limits of a coordinate, held at accumulator width.
    localparam logic signed [ACC_W-1:0] COORD_MAX =
        {{(ACC_W - COORD_W + 1){1'b0}}, {(COORD_W - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] COORD_MIN = ~COORD_MAX;

    // Opcodes of an input beat.
    localparam logic OPCODE_LOAD = 1'b0;
    localparam logic OPCODE_EVAL = 1'b1;

    // Parameter select, square select and coordinate select codes.
    localparam logic       PAR_U   = 1'b0;
    localparam logic       PAR_V   = 1'b1;
    localparam logic [1:0] SQ_T    = 2'd0;
    localparam logic [1:0] SQ_S    = 2'd1;
    localparam logic [1:0] COORD_X = 2'd0;
    localparam logic [1:0] COORD_Y = 2'd1;
    localparam logic [1:0] COORD_Z = 2'd2;

    // Sequencer step limits.
    localparam logic [3:0] WEIGHT_LAST = 4'd11;
    localparam logic [3:0] ROW_LAST    = 4'd15;
    localparam logic [1:0] TERM_FIRST  = 2'd0;
    localparam logic [1:0] TERM_LAST   = 2'd3;

    typedef struct packed {
        logic                      opcode;
        logic [3:0]                point_index;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
        logic [PARAM_W-1:0]        param_u;
        logic [PARAM_W-1:0]        param_v;
    } in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic signed [COORD_W-1:0] out_z;
        logic                      overflow;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WEIGHT,
        ST_ROW,
        ST_COL,
        ST_FINISH
    } state_t;

    // Kind of product: square of a parameter, basis weight, row term, column term.
    typedef enum logic [1:0] {
        OP_SQ,
        OP_WT,
        OP_ROW,
        OP_COL
    } op_kind_t;

    typedef enum logic [1:0] {
        BIAS_NONE,
        BIAS_WEIGHT,
        BIAS_ROUND
    } bias_t;

    typedef struct packed {
        op_kind_t   kind;
        logic       par;
        logic [1:0] k;
        logic [1:0] row;
        logic [1:0] coord;
    } op_t;

    typedef struct packed {
        logic  valid;
        logic  first;
        logic  last;
        bias_t bias;
        op_t   op;
    } mac_ctl_t;

    typedef struct packed {
        logic                    valid;
        op_t                     op;
        logic signed [ACC_W-1:0] value;
    } mac_wb_t;

    typedef struct packed {
        logic in_ready;
        logic out_load;
    } seq_status_t;

    // Weight schedule: squares first, then the four Bernstein weights of v and
    // of u, ordered so that every product finds its square already written.
    function automatic op_t weight_op(input logic [3:0] step);
        op_t op;
        op.kind  = OP_WT;
        op.par   = PAR_V;
        op.k     = 2'd0;
        op.row   = 2'd0;
        op.coord = COORD_X;
        unique case (step)
            4'd0:  begin op.kind = OP_SQ; op.k = SQ_T; end
            4'd1:  begin op.kind = OP_SQ; op.k = SQ_S; end
            4'd2:  begin op.kind = OP_SQ; op.par = PAR_U; op.k = SQ_T; end
            4'd3:  begin op.kind = OP_SQ; op.par = PAR_U; op.k = SQ_S; end
            4'd4:  op.k = 2'd3;
            4'd5:  op.k = 2'd0;
            4'd6:  op.k = 2'd2;
            4'd7:  op.k = 2'd1;
            4'd8:  begin op.par = PAR_U; op.k = 2'd3; end
            4'd9:  begin op.par = PAR_U; op.k = 2'd0; end
            4'd10: begin op.par = PAR_U; op.k = 2'd2; end
            4'd11: begin op.par = PAR_U; op.k = 2'd1; end
            default: op.k = 2'd0;
        endcase
        return op;
    endfunction

endpackage

/* rtl/bbp_ram.sv */
// ============================================================================
// bbp_ram: generic single write port, single read port RAM
// One write and one registered read per cycle; contents are not reset.
// ============================================================================
module bbp_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Storage array and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/bbp_mac.sv */
// ============================================================================
// bbp_mac: shared multiply-accumulate unit
// A registered signed multiplier followed by an accumulator that is preloaded
// with a rounding offset on the first product of a chain. The last product of
// a chain hands the scaled sum back together with its destination tag.
// ============================================================================
module bbp_mac (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic signed [bbp_pkg::OP_W-1:0]   op_a,
    input  logic signed [bbp_pkg::OP_W-1:0]   op_b,
    input  bbp_pkg::mac_ctl_t                 ctl,
    output bbp_pkg::mac_wb_t                  wb,
    output logic                              busy
);

    import bbp_pkg::*;

    logic signed [ACC_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [ACC_W-1:0] bias_val;
    mac_ctl_t                ctl1_reg, ctl2_reg;

    // Control tags follow the data through both stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end
        else
        begin
            ctl1_reg <= ctl;
            ctl2_reg <= ctl1_reg;
        end
    end

    // Product and accumulator registers.
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (ctl1_reg.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    // Multiply, then accumulate onto the running sum or the rounding offset.
    always_comb
    begin
        prod_next = op_a * op_b;
        unique case (ctl1_reg.bias)
            BIAS_NONE:   bias_val = '0;
            BIAS_WEIGHT: bias_val = HALF_WEIGHT;
            BIAS_ROUND:  bias_val = HALF_ROUND;
            default:     bias_val = '0;
        endcase
        acc_next = (ctl1_reg.first ? bias_val : acc_reg) + prod_reg;
    end

    // Scale the finished sum back by the fraction bits that its chain carries.
    always_comb
    begin
        wb.valid = ctl2_reg.valid && ctl2_reg.last;
        wb.op    = ctl2_reg.op;
        unique case (ctl2_reg.bias)
            BIAS_NONE:   wb.value = acc_reg;
            BIAS_WEIGHT: wb.value = acc_reg >>> WEIGHT_DROP;
            BIAS_ROUND:  wb.value = acc_reg >>> WEIGHT_BITS;
            default:     wb.value = acc_reg;
        endcase
    end

    assign busy = ctl1_reg.valid || ctl2_reg.valid;

endmodule

/* rtl/bbp_seq.sv */
// ============================================================================
// bbp_seq: micro-op sequencer of the patch evaluator
// Steps through the weight schedule, then four row sums and one column sum
// for each coordinate, issuing one product a cycle to the shared unit.
// ============================================================================
module bbp_seq (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            eval_start,
    input  logic                            out_free,
    input  logic                            mac_busy,
    output bbp_pkg::seq_status_t            status,
    output bbp_pkg::mac_ctl_t               iss,
    output logic [bbp_pkg::POINT_AW-1:0]    rd_addr
);

    import bbp_pkg::*;

    state_t     state_reg, state_next;
    logic [3:0] step_reg, step_next;
    logic [1:0] coord_reg, coord_next;
    mac_ctl_t   iss_reg, iss_next;

    // State, counters and the issue register that lines up with the RAM read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            coord_reg <= COORD_X;
            iss_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            coord_reg <= coord_next;
            iss_reg   <= iss_next;
        end
    end

    // Next state and the micro-op emitted this cycle.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        coord_next = coord_reg;
        iss_next   = '0;
        status     = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                status.in_ready = 1'b1;
                if (eval_start)
                begin
                    state_next = ST_WEIGHT;
                    step_next  = '0;
                    coord_next = COORD_X;
                end
            end
            ST_WEIGHT:
            begin
                iss_next.valid = 1'b1;
                iss_next.first = 1'b1;
                iss_next.last  = 1'b1;
                iss_next.op    = weight_op(step_reg);
                iss_next.bias  = (iss_next.op.kind == OP_SQ) ? BIAS_NONE : BIAS_WEIGHT;
                if (step_reg == WEIGHT_LAST)
                begin
                    state_next = ST_ROW;
                    step_next  = '0;
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            end
            ST_ROW:
            begin
                iss_next.valid    = 1'b1;
                iss_next.first    = (step_reg[1:0] == TERM_FIRST);
                iss_next.last     = (step_reg[1:0] == TERM_LAST);
                iss_next.bias     = BIAS_ROUND;
                iss_next.op.kind  = OP_ROW;
                iss_next.op.k     = step_reg[1:0];
                iss_next.op.row   = step_reg[3:2];
                iss_next.op.coord = coord_reg;
                if (step_reg == ROW_LAST)
                begin
                    state_next = ST_COL;
                    step_next  = '0;
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            end
            ST_COL:
            begin
                iss_next.valid    = 1'b1;
                iss_next.first    = (step_reg[1:0] == TERM_FIRST);
                iss_next.last     = (step_reg[1:0] == TERM_LAST);
                iss_next.bias     = BIAS_ROUND;
                iss_next.op.kind  = OP_COL;
                iss_next.op.k     = step_reg[1:0];
                iss_next.op.coord = coord_reg;
                if (step_reg[1:0] == TERM_LAST)
                begin
                    step_next = '0;
                    if (coord_reg == COORD_Z)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_ROW;
                        coord_next = coord_reg + 2'd1;
                    end
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            end
            ST_FINISH:
            begin
                // Wait for the last column sum to land and for a free output slot.
                if (!iss_reg.valid && !mac_busy && out_free)
                begin
                    status.out_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign iss     = iss_reg;
    assign rd_addr = step_reg[POINT_AW-1:0];

endmodule

/* rtl/bicubic_bezier_patch_point_top.sv */
// ============================================================================
// bicubic_bezier_patch_point_top: bicubic Bezier patch point evaluator
// Stores a 4x4 grid of control points and evaluates U*M*P*M*V per coordinate
// with one shared multiply-accumulate unit.
// ============================================================================
// Usage:
// The request channel (req_valid, req_ready, req_data) carries two kinds of
// beat. A load beat writes one control point (x, y, z) at point_index and is
// taken without a result and leaves the block ready. An evaluate beat brings u and v
// in unsigned Q1.16 (values above one count as one) and returns one result
// beat on the response channel (res_valid, res_ready, res_data) with the
// saturated point and an overflow flag.
// An evaluate beat keeps the block busy from its acceptance until its result
// is loaded into the output register. The busy time, besides any wait for
// that register, is set by the single 34x34 multiply-accumulate unit, which
// forms 72 products one per cycle (12 for the basis weights, 20 per coordinate)
// plus the drain of its two pipeline stages and the issue register.
// A finished result sits in an output register; while it waits, the block
// still takes load beats and a new evaluate, and a second finished result
// waits inside the block until the register frees up.
// Reset clears only the control state; control points are undefined until
// they are written, and no point may be evaluated before all 16 are loaded.
// ============================================================================
module bicubic_bezier_patch_point_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  bbp_pkg::in_t   req_data,
    output logic           res_valid,
    input  logic           res_ready,
    output bbp_pkg::out_t  res_data
);

    import bbp_pkg::*;

    seq_status_t          status;
    mac_ctl_t             iss;
    mac_wb_t              wb;
    logic                 mac_busy;
    logic [POINT_AW-1:0]  rd_addr;
    logic [POINT_W-1:0]   rd_data;
    logic                 in_fire, load_fire, eval_start, out_free;

    // Parameter values, their complements and triples, one set each for u and v.
    logic [PARAM_W-1:0]   t_reg [2];
    logic [PARAM_W-1:0]   s_reg [2];
    logic [THREE_W-1:0]   t3_reg [2];
    logic [THREE_W-1:0]   s3_reg [2];
    logic [PARAM_W-1:0]   u_clamp, v_clamp, u_comp, v_comp;

    // Intermediate results of the shared unit.
    logic [SQ_W-1:0]         sq_reg [4];
    logic [WT_W-1:0]         wu_reg [4];
    logic [WT_W-1:0]         wv_reg [4];
    logic signed [OP_W-1:0]  row_reg [4];
    logic signed [COORD_W-1:0] res_x_reg, res_y_reg, res_z_reg;
    logic                    ovf_reg;

    // Operand selection.
    logic [PARAM_W-1:0]        t_sel, s_sel, sq_base;
    logic [THREE_W-1:0]        t3_sel, s3_sel;
    logic [SQ_W-1:0]           sq_sel;
    logic signed [COORD_W-1:0] pt_coord;
    logic signed [OP_W-1:0]    op_a, op_b;

    // Saturation of a column sum.
    logic                      sat_hi, sat_lo;
    logic signed [COORD_W-1:0] sat_value;

    // Output register.
    out_t out_reg;
    logic out_valid_reg, out_valid_next;

    function automatic logic [THREE_W-1:0] times_three(input logic [PARAM_W-1:0] x);
        return {2'b00, x} + {1'b0, x, 1'b0};
    endfunction

    // Request handshake.
    assign req_ready  = status.in_ready;
    assign in_fire    = req_valid && status.in_ready;
    assign load_fire  = in_fire && (req_data.opcode == OPCODE_LOAD);
    assign eval_start = in_fire && (req_data.opcode == OPCODE_EVAL);
    assign out_free   = !out_valid_reg || res_ready;

    // Parameters above one count as one.
    assign u_clamp = (req_data.param_u > PARAM_ONE) ? PARAM_ONE : req_data.param_u;
    assign v_clamp = (req_data.param_v > PARAM_ONE) ? PARAM_ONE : req_data.param_v;
    assign u_comp  = PARAM_ONE - u_clamp;
    assign v_comp  = PARAM_ONE - v_clamp;

    bbp_ram #(
        .WIDTH (POINT_W),
        .DEPTH (NUM_POINTS)
    ) u_points (
        .clk     (clk),
        .wr_en   (load_fire),
        .wr_addr (req_data.point_index),
        .wr_data ({req_data.coord_x, req_data.coord_y, req_data.coord_z}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bbp_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .eval_start (eval_start),
        .out_free   (out_free),
        .mac_busy   (mac_busy),
        .status     (status),
        .iss        (iss),
        .rd_addr    (rd_addr)
    );

    bbp_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .op_a  (op_a),
        .op_b  (op_b),
        .ctl   (iss),
        .wb    (wb),
        .busy  (mac_busy)
    );

    // Operand multiplexer in front of the shared unit.
    always_comb
    begin
        t_sel   = t_reg[iss.op.par];
        s_sel   = s_reg[iss.op.par];
        t3_sel  = t3_reg[iss.op.par];
        s3_sel  = s3_reg[iss.op.par];
        sq_sel  = sq_reg[{iss.op.par, ~iss.op.k[1]}];
        sq_base = (iss.op.k == SQ_S) ? s_sel : t_sel;
        unique case (iss.op.coord)
            COORD_X: pt_coord = rd_data[3*COORD_W-1 -: COORD_W];
            COORD_Y: pt_coord = rd_data[2*COORD_W-1 -: COORD_W];
            COORD_Z: pt_coord = rd_data[COORD_W-1:0];
            default: pt_coord = rd_data[COORD_W-1:0];
        endcase
        op_a = '0;
        op_b = '0;
        unique case (iss.op.kind)
            OP_SQ:
            begin
                op_a = $signed({{(OP_W - PARAM_W){1'b0}}, sq_base});
                op_b = $signed({{(OP_W - PARAM_W){1'b0}}, sq_base});
            end
            OP_WT:
            begin
                // Bernstein weights: s^3, 3t*s^2, 3s*t^2, t^3.
                op_a = $signed({{(OP_W - SQ_W){1'b0}}, sq_sel});
                unique case (iss.op.k)
                    2'd0: op_b = $signed({{(OP_W - PARAM_W){1'b0}}, s_sel});
                    2'd1: op_b = $signed({{(OP_W - THREE_W){1'b0}}, t3_sel});
                    2'd2: op_b = $signed({{(OP_W - THREE_W){1'b0}}, s3_sel});
                    2'd3: op_b = $signed({{(OP_W - PARAM_W){1'b0}}, t_sel});
                    default: op_b = '0;
                endcase
            end
            OP_ROW:
            begin
                op_a = $signed({{(OP_W - WT_W){1'b0}}, wv_reg[iss.op.k]});
                op_b = {{(OP_W - COORD_W){pt_coord[COORD_W-1]}}, pt_coord};
            end
            OP_COL:
            begin
                op_a = $signed({{(OP_W - WT_W){1'b0}}, wu_reg[iss.op.k]});
                op_b = row_reg[iss.op.k];
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // Saturate a column sum to the coordinate range.
    always_comb
    begin
        sat_hi = (wb.value > COORD_MAX);
        sat_lo = (wb.value < COORD_MIN);
        if (sat_hi)
        begin
            sat_value = COORD_MAX[COORD_W-1:0];
        end
        else if (sat_lo)
        begin
            sat_value = COORD_MIN[COORD_W-1:0];
        end
        else
        begin
            sat_value = wb.value[COORD_W-1:0];
        end
    end

    // Parameter capture and write-back of the shared unit's results.
    always_ff @(posedge clk)
    begin
        if (eval_start)
        begin
            t_reg[PAR_U]  <= u_clamp;
            s_reg[PAR_U]  <= u_comp;
            t3_reg[PAR_U] <= times_three(u_clamp);
            s3_reg[PAR_U] <= times_three(u_comp);
            t_reg[PAR_V]  <= v_clamp;
            s_reg[PAR_V]  <= v_comp;
            t3_reg[PAR_V] <= times_three(v_clamp);
            s3_reg[PAR_V] <= times_three(v_comp);
            ovf_reg       <= 1'b0;
        end
        if (wb.valid)
        begin
            unique case (wb.op.kind)
                OP_SQ:
                begin
                    sq_reg[{wb.op.par, wb.op.k[0]}] <= wb.value[SQ_W-1:0];
                end
                OP_WT:
                begin
                    if (wb.op.par == PAR_U)
                    begin
                        wu_reg[wb.op.k] <= wb.value[WT_W-1:0];
                    end
                    else
                    begin
                        wv_reg[wb.op.k] <= wb.value[WT_W-1:0];
                    end
                end
                OP_ROW:
                begin
                    row_reg[wb.op.row] <= wb.value[OP_W-1:0];
                end
                OP_COL:
                begin
                    unique case (wb.op.coord)
                        COORD_X: res_x_reg <= sat_value;
                        COORD_Y: res_y_reg <= sat_value;
                        COORD_Z: res_z_reg <= sat_value;
                        default: res_z_reg <= sat_value;
                    endcase
                    if (sat_hi || sat_lo)
                    begin
                        ovf_reg <= 1'b1;
                    end
                end
                default:
                begin
                    ovf_reg <= ovf_reg;
                end
            endcase
        end
    end

    // Result beat valid flag.
    always_comb
    begin
        if (status.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Result beat payload.
    always_ff @(posedge clk)
    begin
        if (status.out_load)
        begin
            out_reg.out_x    <= res_x_reg;
            out_reg.out_y    <= res_y_reg;
            out_reg.out_z    <= res_z_reg;
            out_reg.overflow <= ovf_reg;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_reg;

endmodule
